// ===== hdl/obme_pkg.sv =====
// Shared types and codes for the order book match engine.
// No dependencies; used by hdl/order_book_match_engine.sv.
package obme_pkg;

  localparam int ACTION_W   = 2;
  localparam int PRICE_W    = 12;
  localparam int QTY_W      = 16;
  localparam int POSITION_W = 20;
  localparam int COST_W     = 28;
  localparam int STATUS_W   = 2;

  localparam logic [ACTION_W-1:0] ACT_ADD       = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CANCEL    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TAKE      = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_TAKE_COST = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_ADIV,
    S_AMOD,
    S_ATOP,
    S_AIDX,
    S_ACHK,
    S_WTOP,
    S_WMRD,
    S_WMCMP,
    S_WLRD,
    S_WLCMP,
    S_SHRD,
    S_SHWR,
    S_TKRD,
    S_TKCALC,
    S_TKACC,
    S_DROP,
    S_DONE
  } state_t;

endpackage

// ===== hdl/order_book_match_engine.sv =====
// Order book match engine: sequencer over the order store, level table and bucket counters.
// Depends on hdl/obme_pkg.sv.
//
// One-sided limit order book, lowest price first, arrival order within a level. After reset
// the block runs a clearing pass over the level table and the mid bucket counters with
// in_ready low. One request is worked at a time; the result sits in an output register
// so the next request can be taken while it waits. A cancel walks the bucket counters:
// over the top counters, then over the mid buckets and the levels it visits (each a read
// of the mid or level memory), then moves each later order in the level up by one slot
// and writes back the counters. A take walks to the lowest non-empty level the same way,
// then for each order consumed does a store read, update and cost accumulate, with a
// counter write back once the order is used up, repeating the walk each time a level
// runs empty. The order store has a single read port.
module order_book_match_engine #(
  parameter int FANOUT      = 16,
  parameter int LEVEL_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [obme_pkg::ACTION_W-1:0]   in_action,
  input  logic [obme_pkg::PRICE_W-1:0]    in_price,
  input  logic [obme_pkg::QTY_W-1:0]      in_quantity,
  input  logic [obme_pkg::POSITION_W-1:0] in_position,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [obme_pkg::COST_W-1:0]     out_cost,
  output logic [obme_pkg::QTY_W-1:0]      out_unfilled,
  output logic [obme_pkg::STATUS_W-1:0]   out_status
);

  localparam int MIDS    = FANOUT * FANOUT;
  localparam int NLEVELS = FANOUT * FANOUT * FANOUT;
  localparam int NSLOTS  = NLEVELS * LEVEL_DEPTH;
  localparam int FW      = $clog2(FANOUT);
  localparam int MW      = $clog2(MIDS);
  localparam int LW      = $clog2(NLEVELS);
  localparam int HW      = $clog2(LEVEL_DEPTH);
  localparam int CW      = $clog2(LEVEL_DEPTH + 1);
  localparam int MCW     = $clog2(FANOUT * LEVEL_DEPTH + 1);
  localparam int TCW     = $clog2(MIDS * LEVEL_DEPTH + 1);
  localparam int TOTW    = $clog2(NSLOTS + 1);
  localparam int SAW     = $clog2(NSLOTS);
  localparam int PW      = (TOTW > obme_pkg::POSITION_W) ? TOTW : obme_pkg::POSITION_W;
  localparam int LVW     = HW + CW;
  localparam int PRODW   = obme_pkg::QTY_W + LW;
  localparam logic [63:0] RECIP = 64'((64'd1 << 32) + 64'(NLEVELS) - 64'd1) / 64'(NLEVELS);

  localparam int QW = obme_pkg::QTY_W;
  localparam int PRW = obme_pkg::PRICE_W;

  // memories
  logic [QW-1:0]  store_mem [NSLOTS];
  logic [LVW-1:0] lvl_mem   [NLEVELS];
  logic [MCW-1:0] mid_mem   [MIDS];

  logic           st_we;
  logic [SAW-1:0] st_waddr, st_raddr;
  logic [QW-1:0]  st_wdata, st_rdata_r;
  logic           lv_we;
  logic [LW-1:0]  lv_waddr, lv_raddr;
  logic [LVW-1:0] lv_wdata, lv_rdata_r;
  logic           md_we;
  logic [MW-1:0]  md_waddr, md_raddr;
  logic [MCW-1:0] md_wdata, md_rdata_r;

  always_ff @(posedge clk) begin
    if (st_we) store_mem[st_waddr] <= st_wdata;
    st_rdata_r <= store_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (lv_we) lvl_mem[lv_waddr] <= lv_wdata;
    lv_rdata_r <= lvl_mem[lv_raddr];
  end

  always_ff @(posedge clk) begin
    if (md_we) mid_mem[md_waddr] <= md_wdata;
    md_rdata_r <= mid_mem[md_raddr];
  end

  // control and working registers
  obme_pkg::state_t state_r, state_nxt;
  logic [LW-1:0]   clr_r, clr_nxt;
  logic [TCW-1:0]  top_r [FANOUT];
  logic [TCW-1:0]  top_nxt [FANOUT];
  logic [TOTW-1:0] total_r, total_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [obme_pkg::ACTION_W-1:0] act_r, act_nxt;
  logic [PRW-1:0]  price_r, price_nxt;
  logic [QW-1:0]   qty_r, qty_nxt;
  logic [QW-1:0]   rem_r, rem_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [PRW-1:0]  div_r, div_nxt;
  logic [FW-1:0]   t_r, t_nxt;
  logic [FW-1:0]   sub_r, sub_nxt;
  logic [MW-1:0]   m_r, m_nxt;
  logic [LW-1:0]   lvl_r, lvl_nxt;
  logic [HW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [MCW-1:0]  midv_r, midv_nxt;
  logic [HW-1:0]   j_r, j_nxt;
  logic [PRODW-1:0] prod_r, prod_nxt;
  logic            gone_r, gone_nxt;
  logic [obme_pkg::COST_W-1:0]   cost_r, cost_nxt;
  logic [obme_pkg::STATUS_W-1:0] stat_r, stat_nxt;
  logic [obme_pkg::COST_W-1:0]   ocost_r, ocost_nxt;
  logic [QW-1:0]   ounf_r, ounf_nxt;
  logic [obme_pkg::STATUS_W-1:0] ostat_r, ostat_nxt;

  function automatic logic [SAW-1:0] slot_addr(input logic [LW-1:0] lvl,
                                               input logic [HW-1:0] head,
                                               input logic [CW-1:0] k);
    logic [CW:0]  off;
    logic [31:0]  a;
    off = (CW+1)'(head) + (CW+1)'(k);
    if (off >= (CW+1)'(LEVEL_DEPTH)) off = off - (CW+1)'(LEVEL_DEPTH);
    a = 32'(lvl) * 32'(LEVEL_DEPTH) + 32'(off);
    return a[SAW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= obme_pkg::S_CLR;
      clr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FANOUT; i++) top_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < FANOUT; i++) top_r[i] <= top_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    price_r <= price_nxt;
    qty_r   <= qty_nxt;
    rem_r   <= rem_nxt;
    pos_r   <= pos_nxt;
    div_r   <= div_nxt;
    t_r     <= t_nxt;
    sub_r   <= sub_nxt;
    m_r     <= m_nxt;
    lvl_r   <= lvl_nxt;
    head_r  <= head_nxt;
    cnt_r   <= cnt_nxt;
    midv_r  <= midv_nxt;
    j_r     <= j_nxt;
    prod_r  <= prod_nxt;
    gone_r  <= gone_nxt;
    cost_r  <= cost_nxt;
    stat_r  <= stat_nxt;
    ocost_r <= ocost_nxt;
    ounf_r  <= ounf_nxt;
    ostat_r <= ostat_nxt;
  end

  always_comb begin
    logic [63:0]   dprod;
    logic [31:0]   modv;
    logic [31:0]   rel;
    logic [FW-1:0] kcnt;
    logic [CW-1:0] lq_cnt;
    logic [HW-1:0] lq_head;
    logic [QW-1:0] mn;
    logic [CW:0]   hinc;

    state_nxt     = state_r;
    clr_nxt       = clr_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    for (int i = 0; i < FANOUT; i++) top_nxt[i] = top_r[i];
    act_nxt   = act_r;
    price_nxt = price_r;
    qty_nxt   = qty_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    div_nxt   = div_r;
    t_nxt     = t_r;
    sub_nxt   = sub_r;
    m_nxt     = m_r;
    lvl_nxt   = lvl_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    midv_nxt  = midv_r;
    j_nxt     = j_r;
    prod_nxt  = prod_r;
    gone_nxt  = gone_r;
    cost_nxt  = cost_r;
    stat_nxt  = stat_r;
    ocost_nxt = ocost_r;
    ounf_nxt  = ounf_r;
    ostat_nxt = ostat_r;

    st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_raddr = '0;
    lv_we = 1'b0; lv_waddr = '0; lv_wdata = '0; lv_raddr = lvl_r;
    md_we = 1'b0; md_waddr = '0; md_wdata = '0; md_raddr = m_r;

    dprod   = '0;
    modv    = '0;
    rel     = '0;
    kcnt    = '0;
    lq_cnt  = lv_rdata_r[CW-1:0];
    lq_head = lv_rdata_r[LVW-1:CW];
    mn      = '0;
    hinc    = '0;

    in_ready = (state_r == obme_pkg::S_IDLE);

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      obme_pkg::S_CLR: begin
        lv_we    = 1'b1;
        lv_waddr = clr_r;
        lv_wdata = '0;
        if (32'(clr_r) < 32'(MIDS)) begin
          md_we    = 1'b1;
          md_waddr = clr_r[MW-1:0];
          md_wdata = '0;
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LW'(NLEVELS - 1)) state_nxt = obme_pkg::S_IDLE;
      end

      obme_pkg::S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_action;
          price_nxt = in_price;
          qty_nxt   = in_quantity;
          cost_nxt  = '0;
          stat_nxt  = obme_pkg::STAT_OK;
          rem_nxt   = '0;
          pos_nxt   = '0;
          t_nxt     = '0;
          case (in_action)
            obme_pkg::ACT_ADD: state_nxt = obme_pkg::S_ADIV;
            obme_pkg::ACT_CANCEL: begin
              if (PW'(in_position) >= PW'(total_r)) begin
                stat_nxt  = obme_pkg::STAT_RANGE;
                state_nxt = obme_pkg::S_DONE;
              end else begin
                pos_nxt   = PW'(in_position);
                state_nxt = obme_pkg::S_WTOP;
              end
            end
            default: begin
              rem_nxt = in_quantity;
              if (in_quantity == '0 || total_r == '0) state_nxt = obme_pkg::S_DONE;
              else state_nxt = obme_pkg::S_WTOP;
            end
          endcase
        end
      end

      // price modulo the number of levels via a reciprocal multiply
      obme_pkg::S_ADIV: begin
        dprod     = 64'(price_r) * RECIP;
        div_nxt   = dprod[32 +: PRW];
        state_nxt = obme_pkg::S_AMOD;
      end

      obme_pkg::S_AMOD: begin
        modv = 32'(price_r) - 32'(div_r) * 32'(NLEVELS);
        if (modv >= 32'(NLEVELS)) modv = modv - 32'(NLEVELS);
        lvl_nxt   = modv[LW-1:0];
        state_nxt = obme_pkg::S_ATOP;
      end

      obme_pkg::S_ATOP: begin
        for (int k = 1; k < FANOUT; k++) begin
          if (32'(lvl_r) >= 32'(k * MIDS)) kcnt = kcnt + 1'b1;
        end
        t_nxt     = kcnt;
        state_nxt = obme_pkg::S_AIDX;
      end

      obme_pkg::S_AIDX: begin
        rel = 32'(lvl_r) - 32'(t_r) * 32'(MIDS);
        for (int k = 1; k < FANOUT; k++) begin
          if (rel >= 32'(k * FANOUT)) kcnt = kcnt + 1'b1;
        end
        m_nxt     = MW'(32'(t_r) * 32'(FANOUT) + 32'(kcnt));
        md_raddr  = m_nxt;
        lv_raddr  = lvl_r;
        state_nxt = obme_pkg::S_ACHK;
      end

      obme_pkg::S_ACHK: begin
        if (lq_cnt >= CW'(LEVEL_DEPTH)) begin
          stat_nxt = obme_pkg::STAT_FULL;
        end else begin
          st_we       = 1'b1;
          st_waddr    = slot_addr(lvl_r, lq_head, lq_cnt);
          st_wdata    = qty_r;
          lv_we       = 1'b1;
          lv_waddr    = lvl_r;
          lv_wdata    = {lq_head, lq_cnt + 1'b1};
          md_we       = 1'b1;
          md_waddr    = m_r;
          md_wdata    = md_rdata_r + 1'b1;
          top_nxt[t_r] = top_r[t_r] + 1'b1;
          total_nxt   = total_r + 1'b1;
        end
        state_nxt = obme_pkg::S_DONE;
      end

      // walk: top counters, then mid buckets, then levels
      obme_pkg::S_WTOP: begin
        if (t_r != FW'(FANOUT - 1) && pos_r >= PW'(top_r[t_r])) begin
          pos_nxt = pos_r - PW'(top_r[t_r]);
          t_nxt   = t_r + 1'b1;
        end else begin
          m_nxt     = MW'(32'(t_r) * 32'(FANOUT));
          sub_nxt   = '0;
          state_nxt = obme_pkg::S_WMRD;
        end
      end

      obme_pkg::S_WMRD: begin
        md_raddr  = m_r;
        state_nxt = obme_pkg::S_WMCMP;
      end

      obme_pkg::S_WMCMP: begin
        if (sub_r != FW'(FANOUT - 1) && pos_r >= PW'(md_rdata_r)) begin
          pos_nxt   = pos_r - PW'(md_rdata_r);
          m_nxt     = m_r + 1'b1;
          sub_nxt   = sub_r + 1'b1;
          state_nxt = obme_pkg::S_WMRD;
        end else begin
          midv_nxt  = md_rdata_r;
          lvl_nxt   = LW'(32'(m_r) * 32'(FANOUT));
          sub_nxt   = '0;
          state_nxt = obme_pkg::S_WLRD;
        end
      end

      obme_pkg::S_WLRD: begin
        lv_raddr  = lvl_r;
        state_nxt = obme_pkg::S_WLCMP;
      end

      obme_pkg::S_WLCMP: begin
        if (sub_r != FW'(FANOUT - 1) && pos_r >= PW'(lq_cnt)) begin
          pos_nxt   = pos_r - PW'(lq_cnt);
          lvl_nxt   = lvl_r + 1'b1;
          sub_nxt   = sub_r + 1'b1;
          state_nxt = obme_pkg::S_WLRD;
        end else begin
          head_nxt = lq_head;
          cnt_nxt  = lq_cnt;
          if (act_r == obme_pkg::ACT_CANCEL) begin
            if (pos_r >= PW'(lq_cnt)) begin
              stat_nxt  = obme_pkg::STAT_RANGE;
              state_nxt = obme_pkg::S_DONE;
            end else begin
              j_nxt = pos_r[HW-1:0];
              if ((CW+1)'(pos_r[HW-1:0]) + 1'b1 < (CW+1)'(lq_cnt))
                state_nxt = obme_pkg::S_SHRD;
              else
                state_nxt = obme_pkg::S_DROP;
            end
          end else begin
            state_nxt = obme_pkg::S_TKRD;
          end
        end
      end

      // close the gap left by a cancelled order
      obme_pkg::S_SHRD: begin
        st_raddr  = slot_addr(lvl_r, head_r, CW'(j_r) + 1'b1);
        state_nxt = obme_pkg::S_SHWR;
      end

      obme_pkg::S_SHWR: begin
        st_we    = 1'b1;
        st_waddr = slot_addr(lvl_r, head_r, CW'(j_r));
        st_wdata = st_rdata_r;
        j_nxt    = j_r + 1'b1;
        if ((CW+1)'(j_r) + 2'd2 < (CW+1)'(cnt_r)) state_nxt = obme_pkg::S_SHRD;
        else state_nxt = obme_pkg::S_DROP;
      end

      obme_pkg::S_TKRD: begin
        st_raddr  = slot_addr(lvl_r, head_r, '0);
        state_nxt = obme_pkg::S_TKCALC;
      end

      obme_pkg::S_TKCALC: begin
        mn        = (st_rdata_r < rem_r) ? st_rdata_r : rem_r;
        st_we     = 1'b1;
        st_waddr  = slot_addr(lvl_r, head_r, '0);
        st_wdata  = st_rdata_r - mn;
        rem_nxt   = rem_r - mn;
        prod_nxt  = PRODW'(mn) * PRODW'(lvl_r);
        gone_nxt  = (st_rdata_r == mn);
        state_nxt = obme_pkg::S_TKACC;
      end

      obme_pkg::S_TKACC: begin
        cost_nxt = cost_r + obme_pkg::COST_W'(prod_r);
        if (gone_r) begin
          hinc     = (CW+1)'(head_r) + 1'b1;
          head_nxt = (hinc == (CW+1)'(LEVEL_DEPTH)) ? '0 : hinc[HW-1:0];
          state_nxt = obme_pkg::S_DROP;
        end else begin
          state_nxt = obme_pkg::S_DONE;
        end
      end

      // one order leaves the level: write back all counters
      obme_pkg::S_DROP: begin
        lv_we        = 1'b1;
        lv_waddr     = lvl_r;
        lv_wdata     = {head_r, cnt_r - 1'b1};
        md_we        = 1'b1;
        md_waddr     = m_r;
        md_wdata     = midv_r - 1'b1;
        top_nxt[t_r] = top_r[t_r] - 1'b1;
        total_nxt    = total_r - 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        midv_nxt     = midv_r - 1'b1;
        if (act_r == obme_pkg::ACT_CANCEL || rem_r == '0) begin
          state_nxt = obme_pkg::S_DONE;
        end else if (cnt_r != CW'(1)) begin
          state_nxt = obme_pkg::S_TKRD;
        end else if (total_r != TOTW'(1)) begin
          pos_nxt   = '0;
          t_nxt     = '0;
          state_nxt = obme_pkg::S_WTOP;
        end else begin
          state_nxt = obme_pkg::S_DONE;
        end
      end

      obme_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          ocost_nxt     = (act_r == obme_pkg::ACT_TAKE_COST) ? cost_r : '0;
          ounf_nxt      = (act_r == obme_pkg::ACT_TAKE || act_r == obme_pkg::ACT_TAKE_COST)
                          ? rem_r : '0;
          ostat_nxt     = stat_r;
          state_nxt     = obme_pkg::S_IDLE;
        end
      end

      default: state_nxt = obme_pkg::S_IDLE;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_cost     = ocost_r;
  assign out_unfilled = ounf_r;
  assign out_status   = ostat_r;

  // one request in flight at a time
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  // an error status never carries a fill result
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != obme_pkg::STAT_OK |-> out_cost == '0 && out_unfilled == '0)
    else $error("error result carries cost or remainder");

  // a finished result waits while the output register is still occupied
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == obme_pkg::S_DONE && out_valid_r && !out_ready |=> state_r == obme_pkg::S_DONE)
    else $error("result overwritten before it was taken");

  // no request during the clearing pass
  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == obme_pkg::S_CLR |-> !in_ready)
    else $error("request accepted during clearing pass");

endmodule
